// ===== hw/rtl/averaged_compass_heading_macros.svh =====
// ----------------------------------------------------------------------------
// averaged_compass_heading_macros.svh
// Assertion macros used by the averaged compass heading port checker.
// ----------------------------------------------------------------------------
`ifndef AVERAGED_COMPASS_HEADING_MACROS_SVH
`define AVERAGED_COMPASS_HEADING_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define ACH_ASSERT_CLK(label, clock, rst_n, prop, msg) \
	label: assert property (@(posedge clock) disable iff (!rst_n) prop) else $error(msg);

// concurrent assertion on the block clock and reset
`define ACH_ASSERT(label, prop, msg) \
	`ACH_ASSERT_CLK(label, clk, arst_n, prop, msg)

`endif

// ===== hw/rtl/ach_pkg.sv =====
// ----------------------------------------------------------------------------
// ach_pkg
// Types, constants and the arctangent table of the averaged compass heading.
// ----------------------------------------------------------------------------
package ach_pkg;

	localparam int WINDOW       = 8;
	localparam int SAMPLE_W     = 16;
	localparam int SUM_W        = SAMPLE_W + $clog2(WINDOW);
	localparam int PRE_SHIFT    = 8;
	localparam int VEC_W        = SUM_W + PRE_SHIFT + 3;
	localparam int CORDIC_STEPS = 16;
	localparam int STEP_W       = $clog2(CORDIC_STEPS);
	localparam int ANG_W        = 22;
	localparam int ANG_FRAC     = 8;
	localparam int DEG_W        = 16;
	localparam int HEAD_W       = 13;
	localparam int IN_TDATA_W   = 2 * SAMPLE_W;
	localparam int OUT_TDATA_W  = ((HEAD_W + 7) / 8) * 8;

	localparam logic signed [ANG_W-1:0] ANG_180   = 22'sd737280;
	localparam logic signed [ANG_W:0]   ANG_ROUND = 23'sd128;
	localparam logic signed [DEG_W-1:0] HEAD_MAX  = 16'sd2880;
	localparam logic signed [DEG_W-1:0] HEAD_OFS  = 16'sd1440;
	localparam logic signed [DEG_W-1:0] HEAD_WRAP = 16'sd5760;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [SUM_W-1:0]    sum_t;
	typedef logic signed [ANG_W-1:0]    angle_t;

	typedef struct packed {
		logic busy;
		logic done;
	} cordic_stat_t;

	// atan(2^-i) in 1/4096 degree
	function automatic angle_t atan_lut(input logic [STEP_W-1:0] idx);
		angle_t a;
		unique case (idx)
			4'd0:  a = 22'sd184320;
			4'd1:  a = 22'sd108810;
			4'd2:  a = 22'sd57492;
			4'd3:  a = 22'sd29184;
			4'd4:  a = 22'sd14649;
			4'd5:  a = 22'sd7331;
			4'd6:  a = 22'sd3667;
			4'd7:  a = 22'sd1833;
			4'd8:  a = 22'sd917;
			4'd9:  a = 22'sd458;
			4'd10: a = 22'sd229;
			4'd11: a = 22'sd115;
			4'd12: a = 22'sd57;
			4'd13: a = 22'sd29;
			4'd14: a = 22'sd14;
			4'd15: a = 22'sd7;
		endcase
		return a;
	endfunction

endpackage

// ===== hw/rtl/ach_cell.sv =====
// ----------------------------------------------------------------------------
// ach_cell
// One sample slot of the averaging window; passes its sample on at each shift.
// ----------------------------------------------------------------------------
module ach_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift_en,
	input  ach_pkg::sample_t x_in,
	input  ach_pkg::sample_t y_in,
	output ach_pkg::sample_t x_out,
	output ach_pkg::sample_t y_out
);

	ach_pkg::sample_t x_q;
	ach_pkg::sample_t y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
		end else if (shift_en) begin
			x_q <= x_in;
			y_q <= y_in;
		end
	end

	assign x_out = x_q;
	assign y_out = y_q;

endmodule

// ===== hw/rtl/ach_window.sv =====
// ----------------------------------------------------------------------------
// ach_window
// Row of sample cells with running sums; the oldest sample leaves the far end.
// ----------------------------------------------------------------------------
module ach_window (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift_en,
	input  ach_pkg::sample_t x_in,
	input  ach_pkg::sample_t y_in,
	output ach_pkg::sum_t    sum_x,
	output ach_pkg::sum_t    sum_y
);

	ach_pkg::sample_t cx [ach_pkg::WINDOW+1];
	ach_pkg::sample_t cy [ach_pkg::WINDOW+1];
	ach_pkg::sum_t    sum_x_q;
	ach_pkg::sum_t    sum_y_q;

	assign cx[0] = x_in;
	assign cy[0] = y_in;

	for (genvar i = 0; i < ach_pkg::WINDOW; i++) begin : g_cell
		ach_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (shift_en),
			.x_in     (cx[i]),
			.y_in     (cy[i]),
			.x_out    (cx[i+1]),
			.y_out    (cy[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
		end else if (shift_en) begin
			sum_x_q <= sum_x_q + ach_pkg::SUM_W'(x_in) - ach_pkg::SUM_W'(cx[ach_pkg::WINDOW]);
			sum_y_q <= sum_y_q + ach_pkg::SUM_W'(y_in) - ach_pkg::SUM_W'(cy[ach_pkg::WINDOW]);
		end
	end

	assign sum_x = sum_x_q;
	assign sum_y = sum_y_q;

endmodule

// ===== hw/rtl/ach_cordic.sv =====
// ----------------------------------------------------------------------------
// ach_cordic
// Iterative vectoring CORDIC, one micro-rotation per cycle; angle in 1/4096 deg.
// ----------------------------------------------------------------------------
module ach_cordic (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  ack,
	input  ach_pkg::sum_t         x_in,
	input  ach_pkg::sum_t         y_in,
	output ach_pkg::angle_t       angle,
	output ach_pkg::cordic_stat_t stat
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]                      state_q;
	logic [ach_pkg::STEP_W-1:0]      step_q;
	logic signed [ach_pkg::VEC_W-1:0] x_q;
	logic signed [ach_pkg::VEC_W-1:0] y_q;
	ach_pkg::angle_t                 z_q;
	logic                            zero_q;

	logic signed [ach_pkg::VEC_W-1:0] xs;
	logic signed [ach_pkg::VEC_W-1:0] ys;
	logic signed [ach_pkg::VEC_W-1:0] dx;
	logic signed [ach_pkg::VEC_W-1:0] dy;

	assign xs = ach_pkg::VEC_W'(x_in) <<< ach_pkg::PRE_SHIFT;
	assign ys = ach_pkg::VEC_W'(y_in) <<< ach_pkg::PRE_SHIFT;
	assign dx = y_q >>> step_q;
	assign dy = x_q >>> step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RUN;
						step_q  <= '0;
					end
				end
				ST_RUN: begin
					step_q <= step_q + 1'b1;
					if (step_q == ach_pkg::STEP_W'(ach_pkg::CORDIC_STEPS - 1))
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (ack)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			zero_q <= (x_in == '0) && (y_in == '0);
			if (xs < 0) begin
				x_q <= -xs;
				y_q <= -ys;
				z_q <= (y_in >= 0) ? ach_pkg::ANG_180 : -ach_pkg::ANG_180;
			end else begin
				x_q <= xs;
				y_q <= ys;
				z_q <= '0;
			end
		end else if (state_q == ST_RUN) begin
			if (y_q > 0) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + ach_pkg::atan_lut(step_q);
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - ach_pkg::atan_lut(step_q);
			end
		end
	end

	assign angle     = zero_q ? '0 : z_q;
	assign stat.busy = (state_q != ST_IDLE);
	assign stat.done = (state_q == ST_DONE);

endmodule

// ===== hw/rtl/averaged_compass_heading.sv =====
// ----------------------------------------------------------------------------
// averaged_compass_heading
// Heading of the moving average of magnetometer samples.
// Input stream: one x/y sample per transfer on s_axis. Each sample enters a
// shift row of WINDOW cells (cleared at reset) and updates the running sums.
// Output stream: one heading per sample on m_axis, in 1/16 degree, the
// angle of the summed vector minus 90 degrees, wrapped into -180..180.
// A result passes the start register, the CORDIC load, the 16 micro-rotations
// of the shared CORDIC and its done state on the way to the output register.
// One sample at a time: s_axis_tready is low from the input transfer until
// the CORDIC result has moved into the output register.
// A stalled result stays in the output register; the next sample is still
// taken and its result waits in the CORDIC until the register frees.
// Reset clears the window, the sums and all handshakes.
// ----------------------------------------------------------------------------
module averaged_compass_heading (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [ach_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // mag_x, mag_y
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [ach_pkg::OUT_TDATA_W-1:0]    m_axis_tdata   // heading
);

	logic                      busy_q;
	logic                      start_q;
	logic                      out_valid_q;
	logic [ach_pkg::HEAD_W-1:0] heading_q;

	logic                      in_xfer;
	logic                      take;
	ach_pkg::sum_t             sum_x;
	ach_pkg::sum_t             sum_y;
	ach_pkg::angle_t           angle;
	ach_pkg::cordic_stat_t     stat;

	logic signed [ach_pkg::ANG_W:0]   rsum;
	logic signed [ach_pkg::ANG_W:0]   rshift;
	logic signed [ach_pkg::DEG_W-1:0] deg;
	logic signed [ach_pkg::DEG_W-1:0] deg_clamp;
	logic signed [ach_pkg::DEG_W-1:0] deg_ofs;
	logic signed [ach_pkg::DEG_W-1:0] deg_wrap;

	assign s_axis_tready = !busy_q;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign take          = stat.done && (!out_valid_q || m_axis_tready);

	ach_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift_en (in_xfer),
		.x_in     (s_axis_tdata[ach_pkg::SAMPLE_W-1:0]),
		.y_in     (s_axis_tdata[ach_pkg::IN_TDATA_W-1:ach_pkg::SAMPLE_W]),
		.sum_x    (sum_x),
		.sum_y    (sum_y)
	);

	ach_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.ack    (take),
		.x_in   (sum_x),
		.y_in   (sum_y),
		.angle  (angle),
		.stat   (stat)
	);

	// round to 1/16 degree, clamp, rotate by -90 degrees and wrap
	always_comb begin
		rsum      = (ach_pkg::ANG_W + 1)'(angle) + ach_pkg::ANG_ROUND;
		rshift    = rsum >>> ach_pkg::ANG_FRAC;
		deg       = rshift[ach_pkg::DEG_W-1:0];
		deg_clamp = deg;
		if (deg > ach_pkg::HEAD_MAX)
			deg_clamp = ach_pkg::HEAD_MAX;
		else if (deg < -ach_pkg::HEAD_MAX)
			deg_clamp = -ach_pkg::HEAD_MAX;
		deg_ofs  = deg_clamp - ach_pkg::HEAD_OFS;
		deg_wrap = (deg_ofs < -ach_pkg::HEAD_MAX) ? deg_ofs + ach_pkg::HEAD_WRAP : deg_ofs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= in_xfer;
			if (in_xfer)
				busy_q <= 1'b1;
			else if (take)
				busy_q <= 1'b0;
			if (take)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			heading_q <= deg_wrap[ach_pkg::HEAD_W-1:0];
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(ach_pkg::OUT_TDATA_W - ach_pkg::HEAD_W){1'b0}}, heading_q};

endmodule

// ===== hw/rtl/ach_checker.sv =====
// ----------------------------------------------------------------------------
// ach_checker
// Port-level checks of the averaged compass heading, bound to the top level.
// ----------------------------------------------------------------------------
`include "averaged_compass_heading_macros.svh"

module ach_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic [ach_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [ach_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	logic                              in_xfer;
	logic                              out_stall;
	logic signed [ach_pkg::HEAD_W-1:0] heading;
	logic                              head_ok;

	assign in_xfer   = s_axis_tvalid && s_axis_tready;
	assign out_stall = m_axis_tvalid && !m_axis_tready;
	assign heading   = m_axis_tdata[ach_pkg::HEAD_W-1:0];
	assign head_ok   = (heading <= ach_pkg::HEAD_MAX) && (heading >= -ach_pkg::HEAD_MAX);

	`ACH_ASSERT(a_busy_after_xfer, in_xfer |=> !s_axis_tready ##1 !s_axis_tready, "early input")
	`ACH_ASSERT(a_heading_range, m_axis_tvalid |-> head_ok, "heading out of range")
	`ACH_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid && $stable(m_axis_tdata), "held result changed")

endmodule

bind averaged_compass_heading ach_checker u_ach_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ===== tb/sv/heading_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_checker
// Watches both streams of the averaged compass heading. Each sample transfer
// updates a private window of WINDOW samples and its running sums. The
// expected heading is computed with a vectoring CORDIC on those sums and
// queued. Each heading transfer is compared with the oldest queued heading.
// The checker reports the first mismatches and counts all of them.
// ----------------------------------------------------------------------------
module heading_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	input  logic                               s_axis_tready,
	input  logic [ach_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // mag_x, mag_y
	input  logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	input  logic [ach_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // heading
	output int                                 fails,
	output int                                 pending,
	output int                                 checked
);
	import ach_pkg::*;

	localparam int     MICRO_STEPS   = 16;
	localparam longint HALF_TURN_Q12 = 180 * 4096;
	localparam longint DEG16_LIMIT   = 2880;
	localparam longint QUARTER_DEG16 = 1440;
	localparam longint FULL_DEG16    = 5760;
	localparam int     REPORT_MAX    = 10;

	// atan(2^-i) in 1/4096 degree
	localparam longint ATAN_Q12 [0:MICRO_STEPS-1] = '{
		184320, 108810, 57492, 29184, 14649, 7331, 3667, 1833,
		917, 458, 229, 115, 57, 29, 14, 7
	};

	sample_t                    win_x [WINDOW];
	sample_t                    win_y [WINDOW];
	int                         slot;
	longint                     sum_x;
	longint                     sum_y;
	logic signed [HEAD_W-1:0]   heading_q [$];
	sample_t                    nx;
	sample_t                    ny;
	logic signed [HEAD_W-1:0]   want;
	logic signed [HEAD_W-1:0]   got;

	function automatic longint vector_angle(input longint x, input longint y);
		longint z;
		longint dx;
		longint dy;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		x = x * 256;
		y = y * 256;
		if (x < 0) begin
			z = (y >= 0) ? HALF_TURN_Q12 : -HALF_TURN_Q12;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < MICRO_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x = x + dx;
				y = y - dy;
				z = z + ATAN_Q12[i];
			end else begin
				x = x - dx;
				y = y + dy;
				z = z - ATAN_Q12[i];
			end
		end
		return z;
	endfunction

	function automatic logic signed [HEAD_W-1:0] heading_of(input longint sx, input longint sy);
		longint d;
		d = (vector_angle(sx, sy) + 128) >>> 8;
		if (d > DEG16_LIMIT)
			d = DEG16_LIMIT;
		if (d < -DEG16_LIMIT)
			d = -DEG16_LIMIT;
		d = d - QUARTER_DEG16;
		if (d < -DEG16_LIMIT)
			d = d + FULL_DEG16;
		return d[HEAD_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++) begin
				win_x[i] = '0;
				win_y[i] = '0;
			end
			slot = 0;
			sum_x = 0;
			sum_y = 0;
			heading_q.delete();
			fails = 0;
			pending = 0;
			checked = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[HEAD_W-1:0];
				if (heading_q.size() == 0) begin
					fails++;
					if (fails <= REPORT_MAX)
						$display("unexpected heading transfer: got %0d", got);
				end else begin
					want = heading_q.pop_front();
					checked++;
					if (got !== want) begin
						fails++;
						if (fails <= REPORT_MAX)
							$display("heading mismatch: expected %0d, got %0d", want, got);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				nx = s_axis_tdata[SAMPLE_W-1:0];
				ny = s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
				sum_x = sum_x + nx - win_x[slot];
				sum_y = sum_y + ny - win_y[slot];
				win_x[slot] = nx;
				win_y[slot] = ny;
				slot = (slot == WINDOW - 1) ? 0 : slot + 1;
				heading_q.push_back(heading_of(sum_x, sum_y));
			end
			pending = heading_q.size();
		end
	end

endmodule

// ===== tb/sv/tb_averaged_compass_heading.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_averaged_compass_heading
// Regression for the averaged compass heading. A directed part covers the
// full-scale corners, the zero vector and the negative x axis. The random
// part mixes slowly turning fields, full-range noise, tiny values and
// single-axis runs. Both streams idle at random, with bursts of back-to-back
// traffic, and a checker alongside the block checks every heading.
// ----------------------------------------------------------------------------
module tb_averaged_compass_heading;
	import ach_pkg::*;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;   // mag_x, mag_y
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0]  m_axis_tdata;        // heading

	int fails;
	int pending;
	int checked;
	int sent = 0;
	bit steady = 1'b0;

	always #5 clk = ~clk;

	averaged_compass_heading uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	heading_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fails         (fails),
		.pending       (pending),
		.checked       (checked)
	);

	function automatic sample_t sat16(input int v);
		if (v > 32767)
			return 16'sd32767;
		if (v < -32768)
			return -16'sd32768;
		return sample_t'(v);
	endfunction

	function automatic int any16();
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	task automatic send_sample(input sample_t x, input sample_t y);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {y, x};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sent++;
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic random_phase(input int count);
		int done;
		int kind;
		int run;
		int bx;
		int by;
		int mag;
		done = 0;
		while (done < count) begin
			if (done % 50 == 0)
				steady = ($urandom_range(0, 2) == 0);
			kind = $urandom_range(0, 9);
			if (kind <= 5) begin
				// slowly turning field around a random direction and size
				run = $urandom_range(8, 24);
				mag = $urandom_range(0, 12);
				bx = any16() >>> mag;
				by = any16() >>> mag;
				repeat (run) begin
					send_sample(sat16(bx + $urandom_range(0, 128) - 64),
						sat16(by + $urandom_range(0, 128) - 64));
					bx = bx + $urandom_range(0, 32) - 16;
					by = by + $urandom_range(0, 32) - 16;
				end
				done += run;
			end else if (kind <= 7) begin
				send_sample(sample_t'(any16()), sample_t'(any16()));
				done++;
			end else if (kind == 8) begin
				// tiny values: zero sums and axis hits
				repeat (WINDOW) send_sample(sample_t'($urandom_range(0, 4) - 2),
					sample_t'($urandom_range(0, 4) - 2));
				done += WINDOW;
			end else begin
				run = $urandom_range(1, 2 * WINDOW);
				bx = any16();
				if ($urandom_range(0, 1))
					repeat (run) send_sample(sample_t'(bx), 16'sd0);
				else
					repeat (run) send_sample(16'sd0, sample_t'(bx));
				done += run;
			end
		end
	endtask

	initial begin : sink
		int hold;
		wait (arst_n);
		@(posedge clk);
		forever begin
			hold = steady ? 0 : $urandom_range(0, 10);
			if (hold > 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero vector with a fresh window, then full-scale corners
		send_sample(16'sd0, 16'sd0);
		send_sample(16'sd32767, 16'sd0);
		send_sample(-16'sd32768, 16'sd0);
		send_sample(16'sd0, 16'sd32767);
		send_sample(16'sd0, -16'sd32768);
		send_sample(16'sd32767, 16'sd32767);
		send_sample(-16'sd32768, -16'sd32768);
		send_sample(-16'sd32768, 16'sd32767);
		send_sample(16'sd32767, -16'sd32768);
		// pure negative x axis, then a window of zeros
		repeat (WINDOW) send_sample(-16'sd1000, 16'sd0);
		repeat (WINDOW) send_sample(16'sd0, 16'sd0);
		drain_results();

		random_phase(300);
		drain_results();
		random_phase(300);
		steady = 1'b0;
		s_axis_tvalid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("%0d samples sent, %0d headings checked", sent, checked);
		$display("covered corners, zero vector, negative x axis, turning fields, noise");
		if (fails == 0 && pending == 0)
			$display("averaged_compass_heading regression: pass");
		else
			$display("averaged_compass_heading regression: fail");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("averaged_compass_heading regression: fail");
		$finish;
	end

endmodule
